@@ rtl/art_pkg.sv @@
// ---------------------------------------------------------------------------
// art_pkg
// Shared widths, command codes, state encoding and interface structs for the
// age replacement table.
// ---------------------------------------------------------------------------
package art_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // field widths
   localparam int CMD_W  = 3;
   localparam int ID_W   = 16;
   localparam int AGE_W  = 16;
   localparam int SLOT_W = 4;

   localparam logic [AGE_W-1:0] AGE_MAX  = '1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_FIND   = 3'd1,
      CMD_OLDEST = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_DELETE = 3'd4,
      CMD_READ   = 3'd5
   } command_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_SINGLE,
      ST_FINISH
   } state_type;

   // table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      logic [ID_W-1:0]  owner;
      logic [AGE_W-1:0] age;
   } write_type;

   // one result beat
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   owner;
      logic [AGE_W-1:0]  age;
   } result_type;

endpackage

@@ rtl/art_table.sv @@
// ---------------------------------------------------------------------------
// art_table
// Entry storage: owner id and age per entry, one read port and one write
// port, cleared by reset.
// ---------------------------------------------------------------------------
module art_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [art_pkg::IDX_W-1:0] rd_index,
   output logic [art_pkg::ID_W-1:0]  rd_owner,
   output logic [art_pkg::AGE_W-1:0] rd_age,
   input  art_pkg::write_type        wr
);
   import art_pkg::*;

   logic [ID_W-1:0]  owner_ff [TABLE_DEPTH];
   logic [AGE_W-1:0] age_ff   [TABLE_DEPTH];

   // write port, everything free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            owner_ff[i] <= '0;
            age_ff[i]   <= '0;
         end
      end else if (wr.en) begin
         owner_ff[wr.index] <= wr.owner;
         age_ff[wr.index]   <= wr.age;
      end
   end

   // read port
   assign rd_owner = owner_ff[rd_index];
   assign rd_age   = age_ff[rd_index];

endmodule

@@ rtl/art_seq.sv @@
// ---------------------------------------------------------------------------
// art_seq
// Command sequencer: walks the table one entry per cycle through a shared
// compare / increment unit for tick, find and find_oldest, and does single
// entry work for insert, delete and read.
// ---------------------------------------------------------------------------
module art_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [art_pkg::CMD_W-1:0]  req_command,
   input  logic [art_pkg::ID_W-1:0]   req_owner_id,
   input  logic [art_pkg::SLOT_W-1:0] req_slot,
   output logic [art_pkg::IDX_W-1:0]  rd_index,
   input  logic [art_pkg::ID_W-1:0]   rd_owner,
   input  logic [art_pkg::AGE_W-1:0]  rd_age,
   output art_pkg::write_type         wr,
   output art_pkg::result_type        res,
   output logic                       res_valid,
   input  logic                       res_take
);
   import art_pkg::*;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   result_type        res_ff, res_in;

   logic              accept;
   logic              walk_cmd;
   logic              is_tick, is_find, is_oldest, is_insert, is_delete, is_read;
   logic              match, older, last, in_range, occupied;
   logic [IDX_W-1:0]  slot_idx;

   assign accept = req_valid && req_ready;

   // decode of the incoming and the held command
   assign walk_cmd  = (req_command == CMD_TICK) || (req_command == CMD_FIND) ||
                      (req_command == CMD_OLDEST);
   assign is_tick   = (cmd_ff == CMD_TICK);
   assign is_find   = (cmd_ff == CMD_FIND);
   assign is_oldest = (cmd_ff == CMD_OLDEST);
   assign is_insert = (cmd_ff == CMD_INSERT);
   assign is_delete = (cmd_ff == CMD_DELETE);
   assign is_read   = (cmd_ff == CMD_READ);

   // shared compare unit on the entry being looked at
   assign match    = (rd_owner == id_ff);
   assign older    = (rd_age > res_ff.age);
   assign occupied = (rd_owner != '0);
   assign last     = (idx_ff == LAST_IDX);
   assign in_range = (32'(slot_ff) < 32'(TABLE_DEPTH));
   assign slot_idx = IDX_W'(slot_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = walk_cmd ? ST_WALK : ST_SINGLE;
         end
         ST_WALK: begin
            if (last || (is_find && match)) state_in = ST_FINISH;
         end
         ST_SINGLE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, table addressing and writes
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      rd_index  = slot_idx;
      wr        = '0;
      wr.index  = slot_idx;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_WALK: begin
            rd_index = idx_ff;
            // aging, saturating at the top
            wr.en    = is_tick && occupied && (rd_age != AGE_MAX);
            wr.index = idx_ff;
            wr.owner = rd_owner;
            wr.age   = rd_age + AGE_W'(1);
         end
         ST_SINGLE: begin
            wr.en    = (is_insert || is_delete) && in_range;
            wr.owner = is_insert ? id_ff : '0;
            wr.age   = '0;
         end
         ST_FINISH: begin
            res_valid = 1'b1;
         end
         default: ;
      endcase
   end

   // walk index and result accumulator
   always_comb begin
      idx_in = idx_ff;
      res_in = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in       = '0;
            res_in       = '0;
            res_in.slot  = (req_command == CMD_FIND) ? '0 : req_slot;
         end
         ST_WALK: begin
            idx_in = idx_ff + IDX_W'(1);
            if (is_find && match) begin
               res_in.hit   = 1'b1;
               res_in.slot  = SLOT_W'(idx_ff);
               res_in.owner = rd_owner;
               res_in.age   = rd_age;
            end else if (is_oldest && ((idx_ff == '0) || older)) begin
               res_in.slot  = SLOT_W'(idx_ff);
               res_in.owner = rd_owner;
               res_in.age   = rd_age;
            end
         end
         ST_SINGLE: begin
            if (in_range && is_insert) begin
               res_in.owner = id_ff;
               res_in.age   = '0;
            end else if (in_range && is_read) begin
               res_in.owner = rd_owner;
               res_in.age   = rd_age;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command capture and datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         id_ff   <= req_owner_id;
         slot_ff <= req_slot;
      end
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

@@ rtl/age_replacement_table_top.sv @@
// ---------------------------------------------------------------------------
// age_replacement_table_top
// Table of owner ids with per-entry ages, driven by tick, find, find_oldest,
// insert, delete and read commands, one result beat per command.
// ---------------------------------------------------------------------------
// The block takes one command at a time. tick, find and find_oldest walk the
// table one entry per cycle through a single compare and increment unit, and
// find ends early at its first match. insert, delete and read touch one entry.
// The result sits in an output register, so the next command is taken while a
// finished beat still waits on rsp_ready. The table is cleared by reset in the
// same cycle and is ready right after.
module age_replacement_table_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [art_pkg::CMD_W-1:0]  req_command,
   input  logic [art_pkg::ID_W-1:0]   req_owner_id,
   input  logic [art_pkg::SLOT_W-1:0] req_slot,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic [art_pkg::SLOT_W-1:0] rsp_slot_out,
   output logic [art_pkg::ID_W-1:0]   rsp_owner_out,
   output logic [art_pkg::AGE_W-1:0]  rsp_age_out
);
   import art_pkg::*;

   logic [IDX_W-1:0] rd_index;
   logic [ID_W-1:0]  rd_owner;
   logic [AGE_W-1:0] rd_age;
   write_type        wr;
   result_type       res;
   logic             res_valid;
   logic             res_take;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;

   // entry storage
   art_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_index (rd_index),
      .rd_owner (rd_owner),
      .rd_age   (rd_age),
      .wr       (wr)
   );

   // command sequencer
   art_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_owner_id (req_owner_id),
      .req_slot     (req_slot),
      .rd_index     (rd_index),
      .rd_owner     (rd_owner),
      .rd_age       (rd_age),
      .wr           (wr),
      .res          (res),
      .res_valid    (res_valid),
      .res_take     (res_take)
   );

   // output register takes a result when empty or draining
   assign res_take     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_take) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_ff <= res;
      end
   end

   // result beat
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_slot_out  = rsp_ff.slot;
   assign rsp_owner_out = rsp_ff.owner;
   assign rsp_age_out   = rsp_ff.age;

endmodule

@@ tb/age_replacement_table_top_tb.sv @@
// ---------------------------------------------------------------------------
// age_replacement_table_top_tb
// Self-checking bench for the age replacement table. A queue of commands
// (a directed opening, then weighted random traffic) feeds a valid/ready
// driver. A monitor keeps a shadow copy of the owner and age tables,
// predicts one result beat per accepted command and checks every result
// beat in order. Both sides idle at random, and the receiver also holds
// off once for a long stretch so the block backs up into its input.
// ---------------------------------------------------------------------------
module age_replacement_table_top_tb;
   import art_pkg::*;

   // codes the block must treat as no-ops
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   localparam int RANDOM_COMMANDS = 1525;
   localparam int IDLE_PERCENT    = 32;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_AFTER      = 300;
   localparam int QUIET_FROM      = 700;
   localparam int QUIET_TO        = 900;
   localparam int DRAIN_CYCLES    = 24;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [ID_W-1:0] ID_POOL [6] = '{
      16'h0001, 16'h00A5, 16'h7FFF, 16'h8000, 16'hBEEF, 16'h1234
   };

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   owner_id;
      logic [SLOT_W-1:0] slot;
   } table_command_type;

   logic              clock;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command   = '0;
   logic [ID_W-1:0]   req_owner_id  = '0;
   logic [SLOT_W-1:0] req_slot      = '0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_slot_out;
   logic [ID_W-1:0]   rsp_owner_out;
   logic [AGE_W-1:0]  rsp_age_out;

   // bench state
   table_command_type command_queue [$];
   result_type        result_queue  [$];
   logic [ID_W-1:0]  owner_shadow [TABLE_DEPTH];
   logic [AGE_W-1:0] age_shadow   [TABLE_DEPTH];
   logic req_fire      = 1'b0;
   int   total_commands = 0;
   int   issued_count   = 0;
   int   accepted_count = 0;
   int   result_count   = 0;
   int   error_count    = 0;
   int   find_hits      = 0;
   int   command_mix [8];
   int   hold_left      = 0;
   bit   hold_done      = 1'b0;

   age_replacement_table_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_owner_id  (req_owner_id),
      .req_slot      (req_slot),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_slot_out  (rsp_slot_out),
      .rsp_owner_out (rsp_owner_out),
      .rsp_age_out   (rsp_age_out)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // shadow table update and expected result for one accepted command
   task automatic apply_table_command(input table_command_type c, output result_type r);
      int found;
      int oldest;
      r = '{hit: 1'b0, slot: c.slot, owner: '0, age: '0};
      case (c.command)
         CMD_TICK: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (owner_shadow[i] != '0 && age_shadow[i] != AGE_MAX)
                  age_shadow[i] = age_shadow[i] + 1'b1;
         end
         CMD_FIND: begin
            found = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (found < 0 && owner_shadow[i] == c.owner_id) found = i;
            if (found >= 0) begin
               r.hit   = 1'b1;
               r.slot  = SLOT_W'(found);
               r.owner = owner_shadow[found];
               r.age   = age_shadow[found];
               find_hits++;
            end else begin
               r.slot = '0;
            end
         end
         CMD_OLDEST: begin
            oldest = 0;
            for (int i = 1; i < TABLE_DEPTH; i++)
               if (age_shadow[i] > age_shadow[oldest]) oldest = i;
            r.slot  = SLOT_W'(oldest);
            r.owner = owner_shadow[oldest];
            r.age   = age_shadow[oldest];
         end
         CMD_INSERT: begin
            owner_shadow[c.slot] = c.owner_id;
            age_shadow[c.slot]   = '0;
            r.owner              = c.owner_id;
         end
         CMD_DELETE: begin
            owner_shadow[c.slot] = '0;
            age_shadow[c.slot]   = '0;
         end
         CMD_READ: begin
            r.owner = owner_shadow[c.slot];
            r.age   = age_shadow[c.slot];
         end
         default: ;
      endcase
   endtask

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [SLOT_W-1:0] slot);
      command_queue.push_back('{command: cmd, owner_id: id, slot: slot});
   endtask

   // mostly ids from a small pool so finds hit, with free and random ids mixed in
   function automatic logic [ID_W-1:0] pick_owner_id();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 30) return ID_W'($urandom_range(65535));
      return ID_POOL[$urandom_range(5)];
   endfunction

   function automatic table_command_type random_command();
      table_command_type c;
      int r;
      r          = $urandom_range(99);
      c.owner_id = pick_owner_id();
      c.slot     = SLOT_W'($urandom_range(15));
      if (r < 22)      c.command = CMD_TICK;
      else if (r < 42) c.command = CMD_FIND;
      else if (r < 52) c.command = CMD_OLDEST;
      else if (r < 72) c.command = CMD_INSERT;
      else if (r < 82) c.command = CMD_DELETE;
      else if (r < 96) c.command = CMD_READ;
      else c.command = ($urandom_range(1) != 0) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      return c;
   endfunction

   // stimulus, drain and verdict
   initial begin
      // directed opening: empty table, equal ages, first-match and free-slot finds
      queue_command(CMD_READ,      16'h0000, 4'd0);
      queue_command(CMD_FIND,      16'h0000, 4'd9);
      queue_command(CMD_OLDEST,    16'h0000, 4'd7);
      queue_command(CMD_FIND,      16'hFFFF, 4'd15);
      queue_command(CMD_TICK,      16'hFFFF, 4'd15);
      queue_command(CMD_INSERT,    16'hFFFF, 4'd0);
      queue_command(CMD_INSERT,    16'h8000, 4'd15);
      queue_command(CMD_INSERT,    16'h0001, 4'd5);
      queue_command(CMD_INSERT,    16'hFFFF, 4'd9);
      queue_command(CMD_TICK,      16'h0000, 4'd0);
      queue_command(CMD_TICK,      16'h5555, 4'd10);
      queue_command(CMD_INSERT,    16'h1234, 4'd5);
      queue_command(CMD_TICK,      16'hAAAA, 4'd5);
      queue_command(CMD_OLDEST,    16'hFFFF, 4'd15);
      queue_command(CMD_FIND,      16'hFFFF, 4'd0);
      queue_command(CMD_FIND,      16'h0000, 4'd0);
      queue_command(CMD_READ,      16'hFFFF, 4'd15);
      queue_command(CMD_DELETE,    16'hFFFF, 4'd0);
      queue_command(CMD_READ,      16'h0000, 4'd0);
      queue_command(CMD_INSERT,    16'h0000, 4'd15);
      queue_command(CMD_OLDEST,    16'h0000, 4'd3);
      queue_command(CMD_UNUSED_LO, 16'hFFFF, 4'd15);
      queue_command(CMD_UNUSED_HI, 16'h8001, 4'd6);
      queue_command(CMD_READ,      16'h0000, 4'd5);
      queue_command(CMD_FIND,      16'hFFFF, 4'd3);

      for (int n = 0; n < RANDOM_COMMANDS; n++)
         command_queue.push_back(random_command());
      total_commands = command_queue.size();

      while (accepted_count < total_commands) @(posedge clock);
      while (result_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += result_queue.size();

      $display("covered %0d commands: tick %0d, find %0d (%0d hits), oldest %0d, insert %0d",
               accepted_count, command_mix[CMD_TICK], command_mix[CMD_FIND], find_hits,
               command_mix[CMD_OLDEST], command_mix[CMD_INSERT]);
      $display("delete %0d, read %0d, unused codes %0d, %0d-cycle receiver hold-off, %0d errors",
               command_mix[CMD_DELETE], command_mix[CMD_READ],
               command_mix[CMD_UNUSED_LO] + command_mix[CMD_UNUSED_HI], HOLD_CYCLES,
               error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // request driver: next beat once the current one is taken
   always @(negedge clock) begin : command_driver
      table_command_type beat;
      bit quiet;
      quiet = (issued_count >= QUIET_FROM) && (issued_count < QUIET_TO);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (command_queue.size() == 0 || (!quiet && $urandom_range(99) < IDLE_PERCENT)) begin
            req_valid <= 1'b0;
         end else begin
            beat = command_queue.pop_front();
            req_valid    <= 1'b1;
            req_command  <= beat.command;
            req_owner_id <= beat.owner_id;
            req_slot     <= beat.slot;
            issued_count++;
         end
      end
   end

   // result receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (result_count >= QUIET_FROM && result_count < QUIET_TO) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin : result_monitor
      table_command_type taken;
      result_type        want;
      result_type        got;
      if (reset) begin
         req_fire <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            owner_shadow[i] = '0;
            age_shadow[i]   = '0;
         end
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            taken = '{command: req_command, owner_id: req_owner_id, slot: req_slot};
            apply_table_command(taken, want);
            result_queue.push_back(want);
            command_mix[req_command]++;
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{hit: rsp_hit, slot: rsp_slot_out, owner: rsp_owner_out, age: rsp_age_out};
            result_count++;
            if (result_queue.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected result beat: hit %0d slot %0d owner %h age %0d",
                           got.hit, got.slot, got.owner, got.age);
            end else begin
               want = result_queue.pop_front();
               if (got.hit !== want.hit || got.slot !== want.slot ||
                   got.owner !== want.owner || got.age !== want.age) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display({"result %0d mismatch: hit %0d/%0d slot %0d/%0d",
                               " owner %h/%h age %0d/%0d"},
                              result_count, want.hit, got.hit, want.slot, got.slot,
                              want.owner, got.owner, want.age, got.age);
               end
            end
         end
      end
   end

endmodule
